### rtl/edge_ssor_sweep_assert.svh
// assertion macros for the edge sweep block
`ifndef EDGE_SSOR_SWEEP_ASSERT_SVH
`define EDGE_SSOR_SWEEP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define ESS_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define ESS_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

// condition holds after the trigger
`define ESS_ASSERT_TWO(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> ##2 (cond)) \
        else $error(msg);

`endif

### rtl/ess_pkg.sv
// types and constants shared by the edge sweep block
package ess_pkg;

    localparam int IDX_W      = 12;
    localparam int VAL_W      = 32;
    localparam int OMEGA_W    = 18;
    localparam int OMEGA_FRAC = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK  = 4'd1;

    localparam logic [OMEGA_W-1:0] OMEGA_RESET = 18'd65536;
    localparam logic [IDX_W-1:0]   SINK_RESET  = 12'd4095;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_FWD  = 2'd1,
        KIND_BWD  = 2'd2,
        KIND_READ = 2'd3
    } ess_kind_t;

    typedef struct packed {
        ess_kind_t                kind;
        logic [IDX_W-1:0]         first_index;
        logic [IDX_W-1:0]         second_index;
        logic signed [VAL_W-1:0]  lower_coeff;
        logic signed [VAL_W-1:0]  upper_coeff;
        logic signed [VAL_W-1:0]  load_value;
        logic                     last_edge;
    } ess_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  result_value;
        logic                     saturated;
        logic                     sweep_done;
    } ess_out_t;

    typedef struct packed {
        logic cap_src;
        logic cap_dst;
        logic src_zero;
        logic dst_zero;
        logic step1;
        logic step2;
        logic step3;
    } ess_ctrl_t;

endpackage

### rtl/ess_ram.sv
// working vector memory, one write port and one registered read port
module ess_ram
    import ess_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output logic signed [VAL_W-1:0] rd_data,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic signed [VAL_W-1:0] wr_data
);

    logic signed [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/ess_alu.sv
// edge update arithmetic: two rounded products with saturation
module ess_alu
    import ess_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  ess_ctrl_t               ctrl,
    input  logic [OMEGA_W-1:0]      omega,
    input  logic signed [VAL_W-1:0] coef,
    input  logic signed [VAL_W-1:0] rd_data,
    output logic signed [VAL_W-1:0] src_value,
    output logic signed [VAL_W-1:0] new_value,
    output logic                    saturated
);

    localparam logic signed [51:0] RND1 = 52'sd1 <<< (OMEGA_FRAC - 1);
    localparam logic signed [64:0] RND2 = 65'sd1 <<< (FRAC_BITS - 1);

    logic signed [VAL_W-1:0] zsrc_reg;
    logic signed [VAL_W-1:0] zdst_reg;
    logic signed [50:0]      prod1_reg;
    logic signed [VAL_W-1:0] t_reg;
    logic                    sat1_reg;
    logic signed [63:0]      prod2_reg;

    logic signed [51:0]      sum1;
    logic signed [51:0]      t_wide;
    logic                    over1;
    logic                    under1;
    logic signed [64:0]      sum2;
    logic signed [64:0]      d_wide;
    logic signed [65:0]      diff;
    logic                    over2;
    logic                    under2;

    always_comb
    begin
        sum1   = 52'(prod1_reg) + RND1;
        t_wide = sum1 >>> OMEGA_FRAC;
        over1  = t_wide > 52'sd2147483647;
        under1 = t_wide < -52'sd2147483648;
    end

    always_comb
    begin
        sum2   = 65'(prod2_reg) + RND2;
        d_wide = sum2 >>> FRAC_BITS;
        diff   = 66'(zdst_reg) - 66'(d_wide);
        over2  = diff > 66'sd2147483647;
        under2 = diff < -66'sd2147483648;
        if (over2)
        begin
            new_value = 32'sh7FFFFFFF;
        end
        else if (under2)
        begin
            new_value = -32'sh80000000;
        end
        else
        begin
            new_value = diff[VAL_W-1:0];
        end
        saturated = sat1_reg | over2 | under2;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_src)
        begin
            zsrc_reg <= ctrl.src_zero ? '0 : rd_data;
        end
        if (ctrl.cap_dst)
        begin
            zdst_reg <= ctrl.dst_zero ? '0 : rd_data;
        end
        if (ctrl.step1)
        begin
            prod1_reg <= $signed({1'b0, omega}) * coef;
        end
        if (ctrl.step2)
        begin
            sat1_reg <= over1 | under1;
            if (over1)
            begin
                t_reg <= 32'sh7FFFFFFF;
            end
            else if (under1)
            begin
                t_reg <= -32'sh80000000;
            end
            else
            begin
                t_reg <= t_wide[VAL_W-1:0];
            end
        end
        if (ctrl.step3)
        begin
            prod2_reg <= t_reg * zsrc_reg;
        end
    end

    assign src_value = zsrc_reg;

endmodule

### rtl/edge_ssor_sweep.sv
// top level: item sequencer, config registers and result register
//
//  channel  signals                               direction  role
//  item     item_valid, item_ready, item          in         load, edge or read request
//  result   result_valid, result_ready, result    out        one result per item
//  cfg      cfg_valid, cfg_ready, cfg_index/data  in         register write, always ready
//
// one item at a time: a load goes IDLE to FIN, a read through SRC, an edge through SRC, DST and MUL
// (two reads of the single memory read port, then the omega product and the vector product)
// reset clears the sequencer, the result register and the result valid flag and sets the config registers to their
// reset values; memory contents stay undefined until loaded, so no clearing pass runs
// a held result stalls only the final write of the next item, not its acceptance
module edge_ssor_sweep
    import ess_pkg::*;
#(
    parameter int VECTOR_DEPTH = 4096,
    parameter int FRAC_BITS    = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  ess_in_t               item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output ess_out_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "edge_ssor_sweep_assert.svh"

    localparam int          ADDR_W  = $clog2(VECTOR_DEPTH);
    localparam logic [31:0] DEPTH32 = 32'(VECTOR_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRC,
        S_DST,
        S_MUL,
        S_FIN
    } state_t;

    state_t                  state_reg;
    ess_out_t                result_reg;
    logic                    result_valid_reg;
    logic [OMEGA_W-1:0]      omega_reg;
    logic [IDX_W-1:0]        sink_reg;

    ess_kind_t               kind_reg;
    logic [IDX_W-1:0]        dst_reg;
    logic                    src_zero_reg;
    logic                    dst_zero_reg;
    logic signed [VAL_W-1:0] coef_reg;
    logic signed [VAL_W-1:0] load_reg;
    logic                    last_reg;

    logic                    accept;
    logic                    fin_fire;
    logic [IDX_W-1:0]        src_sel;
    logic [IDX_W-1:0]        dst_sel;
    logic signed [VAL_W-1:0] coef_sel;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic signed [VAL_W-1:0] rd_data;
    logic                    mem_wr_en;
    logic signed [VAL_W-1:0] wr_value;
    logic signed [VAL_W-1:0] src_value;
    logic signed [VAL_W-1:0] new_value;
    logic                    alu_sat;
    ess_ctrl_t               ctrl;
    ess_out_t                result_next;

    function automatic logic idx_zero(input logic [IDX_W-1:0] idx,
                                      input logic [IDX_W-1:0] sink);
        return (idx == sink) || (32'(idx) >= DEPTH32);
    endfunction

    assign item_ready   = state_reg == S_IDLE;
    assign accept       = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign fin_fire     = (state_reg == S_FIN) && (!result_valid_reg || result_ready);

    always_comb
    begin
        case (item.kind)
            KIND_FWD:
            begin
                src_sel  = item.first_index;
                dst_sel  = item.second_index;
                coef_sel = item.lower_coeff;
            end
            KIND_BWD:
            begin
                src_sel  = item.second_index;
                dst_sel  = item.first_index;
                coef_sel = item.upper_coeff;
            end
            default:
            begin
                src_sel  = item.first_index;
                dst_sel  = item.first_index;
                coef_sel = item.lower_coeff;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omega_reg <= OMEGA_RESET;
            sink_reg  <= SINK_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OMEGA: omega_reg <= cfg_data[OMEGA_W-1:0];
                CFG_SINK:  sink_reg  <= cfg_data[IDX_W-1:0];
                default:   ;
            endcase
        end
    end

    // item fields held for the whole sequence
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= item.kind;
            dst_reg      <= dst_sel;
            src_zero_reg <= idx_zero(src_sel, sink_reg);
            dst_zero_reg <= idx_zero(dst_sel, sink_reg);
            coef_reg     <= coef_sel;
            load_reg     <= item.load_value;
            last_reg     <= item.last_edge;
        end
    end

    always_comb
    begin
        rd_en   = (accept && item.kind != KIND_LOAD) || (state_reg == S_SRC);
        rd_addr = accept ? ADDR_W'(src_sel) : ADDR_W'(dst_reg);
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.src_zero = src_zero_reg;
        ctrl.dst_zero = dst_zero_reg;
        ctrl.cap_src  = state_reg == S_SRC;
        ctrl.step1    = state_reg == S_SRC;
        ctrl.cap_dst  = state_reg == S_DST;
        ctrl.step2    = state_reg == S_DST;
        ctrl.step3    = state_reg == S_MUL;
    end

    always_comb
    begin
        result_next = '0;
        case (kind_reg)
            KIND_LOAD:
            begin
                result_next.result_value = load_reg;
            end
            KIND_READ:
            begin
                result_next.result_value = src_value;
            end
            default:
            begin
                result_next.result_value = new_value;
                result_next.saturated    = alu_sat;
                result_next.sweep_done   = last_reg;
            end
        endcase
        wr_value  = result_next.result_value;
        mem_wr_en = fin_fire && (kind_reg != KIND_READ) && !dst_zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (fin_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (item.kind == KIND_LOAD) ? S_FIN : S_SRC;
                    end
                end
                S_SRC:
                begin
                    state_reg <= (kind_reg == KIND_READ) ? S_FIN : S_DST;
                end
                S_DST:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (fin_fire)
                    begin
                        result_reg <= result_next;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    ess_ram #(
        .DEPTH  (VECTOR_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (ADDR_W'(dst_reg)),
        .wr_data (wr_value)
    );

    ess_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk       (clk),
        .ctrl      (ctrl),
        .omega     (omega_reg),
        .coef      (coef_reg),
        .rd_data   (rd_data),
        .src_value (src_value),
        .new_value (new_value),
        .saturated (alu_sat)
    );

    `ESS_ASSERT_SAME(a_write_only_at_finish, mem_wr_en, state_reg == S_FIN && fin_fire, "memory write outside finish")
    `ESS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != S_IDLE, "accepted item did not start")
    `ESS_ASSERT_NEXT(a_stall_holds_finish, state_reg == S_FIN && result_valid_reg && !result_ready, state_reg == S_FIN && result_valid_reg, "finish left while result held")
    `ESS_ASSERT_TWO(a_read_reaches_finish, accept && item.kind == KIND_READ, state_reg == S_FIN, "read item did not reach finish")

endmodule

### sim/tb.sv
// self-checking testbench for edge_ssor_sweep: directed and random load, edge and read items
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ess_pkg::*;

    localparam int     ITEM_TARGET  = 1050;
    localparam int     QUIET_LIMIT  = 4000;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     VEC_DEPTH    = 4096;
    localparam int     FRAC         = 16;
    localparam longint VAL_MAX      = 64'sd2147483647;
    localparam longint VAL_MIN      = -64'sd2147483648;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    ess_in_t               item;
    logic                  result_valid;
    logic                  result_ready;
    ess_out_t              result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [OMEGA_W-1:0]      omega_q;
    logic [IDX_W-1:0]        sink_q;
    logic signed [VAL_W-1:0] vec_model [VEC_DEPTH];
    bit                      vec_written [VEC_DEPTH];
    int                      written_list[$];
    ess_out_t                pending_results[$];
    int                      mismatches;
    int                      items_sent;
    int                      quiet_cycles;
    bit                      no_idle;

    edge_ssor_sweep uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [VAL_W-1:0] vec_fetch(logic [IDX_W-1:0] idx);
        if (idx == sink_q)
            return '0;
        return vec_model[idx];
    endfunction

    function automatic void vec_store(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] v);
        if (idx == sink_q)
            return;
        vec_model[idx] = v;
        if (!vec_written[idx])
        begin
            vec_written[idx] = 1'b1;
            written_list.push_back(int'(idx));
        end
    endfunction

    function automatic longint clamp_val(longint v, inout bit sat);
        if (v > VAL_MAX)
        begin
            sat = 1'b1;
            return VAL_MAX;
        end
        if (v < VAL_MIN)
        begin
            sat = 1'b1;
            return VAL_MIN;
        end
        return v;
    endfunction

    // z_dst - round(round(omega * c) * z_src), both steps clamped
    function automatic logic signed [VAL_W-1:0] relax_update(
        logic signed [VAL_W-1:0] zdst,
        logic signed [VAL_W-1:0] zsrc,
        logic signed [VAL_W-1:0] c,
        inout bit sat
    );
        longint t;
        longint d;
        longint nv;
        t = (longint'(omega_q) * longint'(c) + (longint'(1) <<< (OMEGA_FRAC - 1)))
            >>> OMEGA_FRAC;
        t = clamp_val(t, sat);
        d = (t * longint'(zsrc) + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        nv = clamp_val(longint'(zdst) - d, sat);
        return nv[VAL_W-1:0];
    endfunction

    function automatic ess_out_t apply_item(ess_in_t it);
        ess_out_t r;
        bit sat;
        r = '0;
        sat = 1'b0;
        case (it.kind)
            KIND_LOAD:
            begin
                r.result_value = it.load_value;
                vec_store(it.first_index, it.load_value);
            end
            KIND_FWD:
            begin
                r.result_value = relax_update(vec_fetch(it.second_index),
                                              vec_fetch(it.first_index), it.lower_coeff, sat);
                vec_store(it.second_index, r.result_value);
                r.saturated = sat;
                r.sweep_done = it.last_edge;
            end
            KIND_BWD:
            begin
                r.result_value = relax_update(vec_fetch(it.first_index),
                                              vec_fetch(it.second_index), it.upper_coeff, sat);
                vec_store(it.first_index, r.result_value);
                r.saturated = sat;
                r.sweep_done = it.last_edge;
            end
            default:
            begin
                r.result_value = vec_fetch(it.first_index);
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        int v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return '0;
                    3: return -32'sd1;
                    default: return 32'sh00010000;
                endcase
            end
            1, 2: return $urandom;
            default:
            begin
                v = $urandom_range(0, 2097152) - 1048576;
                return v;
            end
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_coeff();
        int v;
        if ($urandom_range(9) == 0)
            return rand_value();
        v = $urandom_range(0, 131072) - 65536;
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if (written_list.size() == 0 || $urandom_range(9) == 0)
            return sink_q;
        return IDX_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
    endfunction

    function automatic ess_in_t noise_item();
        ess_in_t it;
        it.kind         = ess_kind_t'($urandom_range(3));
        it.first_index  = IDX_W'($urandom);
        it.second_index = IDX_W'($urandom);
        it.lower_coeff  = $urandom;
        it.upper_coeff  = $urandom;
        it.load_value   = $urandom;
        it.last_edge    = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic ess_in_t make_item(ess_kind_t kind, int fi, int si,
                                          logic signed [VAL_W-1:0] lo,
                                          logic signed [VAL_W-1:0] up,
                                          logic signed [VAL_W-1:0] ld, int last);
        ess_in_t it;
        it.kind         = kind;
        it.first_index  = IDX_W'(fi);
        it.second_index = IDX_W'(si);
        it.lower_coeff  = lo;
        it.upper_coeff  = up;
        it.load_value   = ld;
        it.last_edge    = 1'(last);
        return it;
    endfunction

    function automatic ess_in_t random_item();
        ess_in_t it;
        it = noise_item();
        case (it.kind)
            KIND_LOAD:
                it.load_value = rand_value();
            KIND_FWD, KIND_BWD:
            begin
                it.first_index  = pick_index();
                it.second_index = ($urandom_range(7) == 0) ? it.first_index : pick_index();
                it.lower_coeff  = rand_coeff();
                it.upper_coeff  = rand_coeff();
            end
            default:
                it.first_index = pick_index();
        endcase
        return it;
    endfunction

    task automatic send_item(ess_in_t it);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 26)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        pending_results.push_back(apply_item(it));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_OMEGA)
            omega_q = data[OMEGA_W-1:0];
        else if (idx == CFG_SINK)
            sink_q = data[IDX_W-1:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // set omega and sink, load a window, sweep it forward and backward, send random items, then read part of it back
    task automatic run_phase(int noise_cnt);
        ess_in_t sweep_q[$];
        ess_in_t it;
        int n;
        int base;
        int m;
        wait_idle();
        case ($urandom_range(9))
            0: cfg_write(CFG_OMEGA, 0);
            1: cfg_write(CFG_OMEGA, 131072);
            2, 3, 4: cfg_write(CFG_OMEGA, 65536);
            default: cfg_write(CFG_OMEGA, $urandom_range(0, 131072));
        endcase
        case ($urandom_range(5))
            0: cfg_write(CFG_SINK, 0);
            1: cfg_write(CFG_SINK, 4095);
            2: cfg_write(CFG_SINK, CFG_DATA_W'(pick_index()));
            default: cfg_write(CFG_SINK, $urandom_range(0, 4095));
        endcase
        n = $urandom_range(3, 16);
        base = $urandom_range(0, VEC_DEPTH - n);
        for (int k = 0; k < n; k++)
        begin
            it = noise_item();
            it.kind = KIND_LOAD;
            it.first_index = IDX_W'(base + k);
            it.load_value = rand_value();
            send_item(it);
        end
        for (int k = 1; k < n; k++)
        begin
            m = $urandom_range(0, k - 1);
            it = noise_item();
            it.kind = KIND_FWD;
            it.first_index = IDX_W'(base + m);
            it.second_index = IDX_W'(base + k);
            it.lower_coeff = rand_coeff();
            it.last_edge = 1'b0;
            sweep_q.push_back(it);
            if (m + 1 < k && $urandom_range(1) == 1)
            begin
                it.first_index = IDX_W'(base + $urandom_range(m + 1, k - 1));
                it.lower_coeff = rand_coeff();
                sweep_q.push_back(it);
            end
        end
        sweep_q[sweep_q.size() - 1].last_edge = 1'b1;
        foreach (sweep_q[q])
            send_item(sweep_q[q]);
        sweep_q.delete();
        for (int k = n - 2; k >= 0; k--)
        begin
            m = $urandom_range(k + 1, n - 1);
            it = noise_item();
            it.kind = KIND_BWD;
            it.first_index = IDX_W'(base + k);
            it.second_index = IDX_W'(base + m);
            it.upper_coeff = rand_coeff();
            it.last_edge = 1'b0;
            sweep_q.push_back(it);
        end
        sweep_q[sweep_q.size() - 1].last_edge = 1'b1;
        foreach (sweep_q[q])
            send_item(sweep_q[q]);
        repeat (noise_cnt)
            send_item(random_item());
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(1) == 1)
            begin
                it = noise_item();
                it.kind = KIND_READ;
                it.first_index = IDX_W'(base + k);
                send_item(it);
            end
        end
    endtask

    task automatic test_directed_defaults();
        send_item(make_item(KIND_LOAD, 0, 7, 0, 0, 32'sh7FFFFFFF, 0));
        send_item(make_item(KIND_LOAD, 1, 0, 0, 0, 32'sh80000000, 1));
        send_item(make_item(KIND_LOAD, 4094, 0, 0, 0, 32'sh00010000, 0));
        send_item(make_item(KIND_LOAD, 4095, 0, 0, 0, 32'sh12345678, 0));
        send_item(make_item(KIND_READ, 4095, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_READ, 0, 0, 0, 0, 0, 1));
        send_item(make_item(KIND_READ, 1, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_FWD, 4094, 0, 32'sh7FFFFFFF, 0, 0, 0));
        send_item(make_item(KIND_FWD, 1, 0, 32'sh7FFFFFFF, 0, 0, 0));
        send_item(make_item(KIND_BWD, 0, 1, 0, 32'sh80000000, 0, 1));
        send_item(make_item(KIND_BWD, 4094, 4094, 0, 32'sh00008000, 0, 0));
        send_item(make_item(KIND_FWD, 4095, 4094, 32'sh00030000, 0, 0, 0));
        send_item(make_item(KIND_FWD, 0, 4095, 32'sh00018000, 0, 0, 1));
        send_item(make_item(KIND_LOAD, 2, 4095, 0, 0, -32'sd1, 0));
        send_item(make_item(KIND_FWD, 2, 2, 32'sh80000000, 0, 0, 1));
        send_item(make_item(KIND_READ, 2, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_READ, 4094, 0, 0, 0, 0, 0));
    endtask

    task automatic test_config_extremes();
        wait_idle();
        cfg_write(CFG_OMEGA, 0);
        cfg_write(CFG_SINK, 0);
        send_item(make_item(KIND_READ, 0, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_LOAD, 0, 0, 0, 0, 32'sh00005555, 0));
        send_item(make_item(KIND_FWD, 2, 1, 32'sh7FFFFFFF, 0, 0, 0));
        send_item(make_item(KIND_BWD, 1, 0, 0, 32'sh00020000, 0, 1));
        wait_idle();
        cfg_write(CFG_OMEGA, 131072);
        cfg_write(CFG_SINK, 4095);
        send_item(make_item(KIND_FWD, 4094, 2, 32'sh7FFFFFFF, 0, 0, 0));
        send_item(make_item(KIND_READ, 0, 0, 0, 0, 0, 0));
        wait_idle();
        cfg_write(4'd2, $urandom);
        cfg_write(4'd15, $urandom);
        send_item(make_item(KIND_BWD, 2, 4094, 0, 32'sh40000000, 0, 1));
        send_item(make_item(KIND_READ, 4095, 0, 0, 0, 0, 0));
        wait_idle();
        cfg_write(CFG_OMEGA, 65536);
    endtask

    task automatic test_random_sweeps(int stop_at);
        while (items_sent < stop_at)
            run_phase($urandom_range(4, 16));
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (4)
            run_phase(8);
        wait_idle();
        no_idle = 1'b0;
    endtask

    always @(negedge clk)
        result_ready <= no_idle || ($urandom_range(99) >= 26);

    always @(posedge clk)
    begin
        ess_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.result_value !== want.result_value)
                begin
                    $error("result_value: expected %0d, got %0d",
                           want.result_value, result.result_value);
                    mismatches++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b", want.saturated, result.saturated);
                    mismatches++;
                end
                if (result.sweep_done !== want.sweep_done)
                begin
                    $error("sweep_done: expected %0b, got %0b",
                           want.sweep_done, result.sweep_done);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else if ((item_valid && item_ready) || (result_valid && result_ready)
                 || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        omega_q      = OMEGA_RESET;
        sink_q       = SINK_RESET;
        mismatches   = 0;
        items_sent   = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_defaults();
        test_config_extremes();
        test_random_sweeps(700);
        test_back_to_back();
        test_random_sweeps(ITEM_TARGET);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ess_pkg.sv
rtl/ess_ram.sv
rtl/ess_alu.sv
rtl/edge_ssor_sweep.sv
sim/tb.sv
